### sv/bsfe_pkg.sv
// shared types and constants for the byte stuffing frame encoder
// no dependencies; used by every module of the block

package bsfe_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_HEADER = 2'd0;
    localparam logic [1:0] REG_FOOTER = 2'd1;
    localparam logic [1:0] REG_ESCAPE = 2'd2;

    // reset values of the marker registers
    localparam logic [7:0] HEADER_RESET = 8'd2;
    localparam logic [7:0] FOOTER_RESET = 8'd3;
    localparam logic [7:0] ESCAPE_RESET = 8'd16;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified payload byte, with the markers in force when it came in
    typedef struct packed {
        logic [7:0] data;
        logic       send_header;
        logic       send_escape;
        logic       close_frame;
        logic [7:0] header_value;
        logic [7:0] footer_value;
        logic [7:0] escape_value;
    } job_t;

    // handshake between front and queue
    typedef struct packed {
        logic push;
    } qctl_t;

    // position of the back end within one job
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ESCAPE,
        PH_DATA,
        PH_FOOT1,
        PH_FOOT2
    } phase_t;

endpackage

### sv/byte_stuffing_frame_encoder.sv
// top level of the byte stuffing frame encoder
// depends on bsfe_pkg, bsfe_front, bsfe_queue, bsfe_back
//
// Usage:
// Payload bytes enter on the s_axis channel, one beat per byte, with tlast
// set on the last byte of each frame. The framed line stream leaves on the
// m_axis channel, one byte per beat: a header byte before the first payload
// byte of a frame, an escape byte before any payload byte equal to one of
// the three markers, and two footer bytes after the last payload byte, the
// second of them carrying tlast. Each input beat gives one to five output
// beats. The cfg channel writes the marker bytes (index 0 header, 1 footer,
// 2 escape); it is always ready and should be used only while the block is
// idle. An accepted input beat passes the job queue and the output register
// before its first output beat. The output register emits one byte per
// cycle while the receiver is ready, so throughput is set by how many line
// bytes each input beat expands into; a two-entry job queue lets input
// beats be taken while the back end works. Reset clears the queue, closes
// any open frame and loads the marker reset values. When the receiver
// stalls, the output beat holds, the queue fills, and s_axis_tready drops.

module byte_stuffing_frame_encoder
    import bsfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] payload_byte
    input  logic       s_axis_tlast,   // is_final
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] line_byte
    output logic       m_axis_tlast,   // frame_done
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    qctl_t qctl;
    job_t  new_job;
    job_t  head_job;
    logic  q_full;
    logic  head_valid;
    logic  pop;

    // classify and enqueue
    bsfe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_full        (q_full),
        .qctl          (qctl),
        .job           (new_job)
    );

    // job queue
    bsfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .qctl       (qctl),
        .wr_job     (new_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // expand into line bytes
    bsfe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### sv/bsfe_front.sv
// front end: takes payload beats and config writes, classifies each byte
// depends on bsfe_pkg

module bsfe_front
    import bsfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] payload_byte
    input  logic       s_axis_tlast,   // is_final
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       q_full,
    output qctl_t      qctl,
    output job_t       job
);

    logic [7:0] header_reg;
    logic [7:0] footer_reg;
    logic [7:0] escape_reg;
    logic       frame_open_reg;
    logic       frame_open_next;
    logic       accept;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // marker registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            footer_reg <= FOOTER_RESET;
            escape_reg <= ESCAPE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HEADER: header_reg <= cfg_data;
                REG_FOOTER: footer_reg <= cfg_data;
                REG_ESCAPE: escape_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // classify the incoming byte
    always_comb
    begin
        job.data         = s_axis_tdata;
        job.send_header  = !frame_open_reg;
        job.send_escape  = (s_axis_tdata == escape_reg) ||
                           (s_axis_tdata == footer_reg) ||
                           (s_axis_tdata == header_reg);
        job.close_frame  = s_axis_tlast;
        job.header_value = header_reg;
        job.footer_value = footer_reg;
        job.escape_value = escape_reg;
        qctl.push        = accept;
    end

    // open frame tracking
    always_comb
    begin
        frame_open_next = frame_open_reg;
        if (accept)
        begin
            frame_open_next = !s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

### sv/bsfe_queue.sv
// short job queue between the front and back ends
// depends on bsfe_pkg

module bsfe_queue
    import bsfe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  qctl_t qctl,
    input  job_t  wr_job,
    input  logic  pop,
    output logic  full,
    output logic  head_valid,
    output job_t  head_job
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (qctl.push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!qctl.push && do_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (qctl.push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (qctl.push)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

### sv/bsfe_back.sv
// back end: expands each job into line bytes through an output register
// depends on bsfe_pkg

module bsfe_back
    import bsfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       pop,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] line_byte
    output logic       m_axis_tlast    // frame_done
);

    phase_t     state_reg;
    phase_t     state_next;
    phase_t     phase;
    logic       load;
    logic [7:0] byte_out;
    logic       done_out;
    logic       tvalid_reg;
    logic       tvalid_next;
    logic [7:0] tdata_reg;
    logic       tlast_reg;

    assign load = head_valid && (!tvalid_reg || m_axis_tready);

    // current phase with unneeded header and escape steps skipped
    always_comb
    begin
        phase = state_reg;
        if (state_reg == PH_HEADER && !head_job.send_header)
        begin
            phase = head_job.send_escape ? PH_ESCAPE : PH_DATA;
        end
        else if (state_reg == PH_ESCAPE && !head_job.send_escape)
        begin
            phase = PH_DATA;
        end
    end

    // next state and byte selection
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        done_out   = 1'b0;
        byte_out   = head_job.data;
        case (phase)
            PH_HEADER:
            begin
                byte_out = head_job.header_value;
                if (load)
                begin
                    state_next = PH_ESCAPE;
                end
            end
            PH_ESCAPE:
            begin
                byte_out = head_job.escape_value;
                if (load)
                begin
                    state_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                byte_out = head_job.data;
                if (load)
                begin
                    if (head_job.close_frame)
                    begin
                        state_next = PH_FOOT1;
                    end
                    else
                    begin
                        state_next = PH_HEADER;
                        pop        = 1'b1;
                    end
                end
            end
            PH_FOOT1:
            begin
                byte_out = head_job.footer_value;
                if (load)
                begin
                    state_next = PH_FOOT2;
                end
            end
            PH_FOOT2:
            begin
                byte_out = head_job.footer_value;
                done_out = 1'b1;
                if (load)
                begin
                    state_next = PH_HEADER;
                    pop        = 1'b1;
                end
            end
            default:
            begin
                state_next = PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // output register
    always_comb
    begin
        tvalid_next = tvalid_reg;
        if (load)
        begin
            tvalid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
        end
        else
        begin
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tdata_reg <= byte_out;
            tlast_reg <= done_out;
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tlast  = tlast_reg;

endmodule

### sv/bsfe_checker.sv
// port level checks for the byte stuffing frame encoder
// depends on byte_stuffing_frame_encoder; attached by the bind below

module bsfe_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // a stalled output beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // input back-pressure only comes with a pending output beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no output pending");

    // a beat taken on an empty output passes the queue and output register
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
        else $error("accepted byte did not reach the output");

endmodule

bind byte_stuffing_frame_encoder bsfe_checker u_bsfe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
